// ===== rtl/assert_macros.svh =====
// assert_macros.svh: concurrent assertion helpers for the checker.
// Needs a clock and an active-low reset in scope at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");

// antecedent implies consequent (property text given whole)
`define ASSERT_PROP(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

`endif

// ===== rtl/b2r_pkg.sv =====
// b2r_pkg: constants, config codes, fixed-point matrix helpers and the
// PQ lookup table built at elaboration. No dependencies.
package b2r_pkg;

  localparam int unsigned SAMPLE_W = 10;
  localparam int unsigned CODE_W   = 10;
  localparam int unsigned PIXEL_W  = 32;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned PQ_DEPTH = 1024;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TEN_BIT_MODE = 2'd0,
    CFG_PQ_ENABLE    = 2'd1
  } cfg_idx_e;

  localparam logic [1:0] ALPHA = 2'b11;

  // Q.16 matrix coefficients with the 1023 output scale folded in
  localparam logic signed [31:0] KY  = 32'sd76533;
  localparam logic signed [31:0] KRV = 32'sd110337;
  localparam logic signed [31:0] KGU = 32'sd12312;
  localparam logic signed [31:0] KGV = 32'sd42751;
  localparam logic signed [31:0] KBU = 32'sd140776;
  localparam logic signed [31:0] CH_MAX = 32'sd67043328;
  localparam logic signed [31:0] HALF_LSB = 32'sd32768;
  localparam logic signed [11:0] Y_OFS = 12'sd64;
  localparam logic signed [11:0] C_OFS = 12'sd512;

  typedef logic [PQ_DEPTH-1:0][CODE_W-1:0] pq_rom_t;

  function automatic logic [CODE_W-1:0] to_code(input logic signed [31:0] acc);
    logic [31:0] s;
    s = 32'(acc + HALF_LSB);
    if (acc < 0) begin
      return '0;
    end else if (acc > CH_MAX) begin
      return CODE_W'(1023);
    end
    return s[25:16];
  endfunction

  // Q8.56 helpers, elaboration only
  localparam logic [63:0] ONE_Q = 64'd1 << 56;

  function automatic logic [63:0] mulq(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = 128'(a) * 128'(b);
    return p[119:56];
  endfunction

  function automatic logic [63:0] divq(input logic [63:0] num, input logic [63:0] den);
    logic [127:0] n;
    logic [127:0] rem;
    logic [63:0]  q;
    n   = 128'(num) << 56;
    rem = '0;
    q   = '0;
    if (den == 64'd0) begin
      return '0;
    end
    for (int k = 119; k >= 0; k--) begin
      rem = {rem[126:0], n[k]};
      q   = {q[62:0], 1'b0};
      if (rem >= 128'(den)) begin
        rem  = rem - 128'(den);
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] sqrtq(input logic [63:0] a);
    logic [127:0] n;
    logic [127:0] sq;
    logic [63:0]  r;
    logic [63:0]  c;
    n = 128'(a) << 56;
    r = '0;
    for (int b = 56; b >= 0; b--) begin
      c  = r | (64'd1 << b);
      sq = 128'(c) * 128'(c);
      if (sq <= n) begin
        r = c;
      end
    end
    return r;
  endfunction

  function automatic logic [63:0] powq(input logic [63:0] base_in, input logic [11:0] e);
    logic [63:0] res;
    logic [63:0] base;
    res  = ONE_Q;
    base = base_in;
    for (int i = 0; i < 12; i++) begin
      if (e[i]) begin
        res = mulq(res, base);
      end
      base = mulq(base, base);
    end
    return res;
  endfunction

  function automatic logic [CODE_W-1:0] pq_entry(input logic [63:0] idx);
    logic [63:0]  s;
    logic [63:0]  x;
    logic [63:0]  t;
    logic [63:0]  sig;
    logic [63:0]  code;
    logic [127:0] p;
    logic [63:0]  c1;
    logic [63:0]  c2;
    logic [63:0]  c3;
    c1 = 64'd3424 << 44;
    c2 = 64'd2413 << 49;
    c3 = 64'd2392 << 49;
    s  = divq(idx, 64'd1023);
    for (int k = 0; k < 13; k++) begin
      s = sqrtq(s);
    end
    x = powq(s, 12'd1305);
    t = divq(c1 + mulq(c2, x), ONE_Q + mulq(c3, x));
    for (int k = 0; k < 5; k++) begin
      t = sqrtq(t);
    end
    sig  = powq(t, 12'd2523);
    p    = 128'(sig) * 128'(1023) + (128'(1) << 55);
    code = p[119:56];
    if (code > 64'd1023) begin
      code = 64'd1023;
    end
    return code[CODE_W-1:0];
  endfunction

  function automatic pq_rom_t build_pq_rom();
    pq_rom_t rom;
    rom = '0;
    for (int i = 0; i < PQ_DEPTH; i++) begin
      rom[i] = pq_entry(64'(i));
    end
    return rom;
  endfunction

  localparam pq_rom_t PQ_ROM = build_pq_rom();

endpackage

// ===== rtl/bt2020_ycbcr_to_rgb10_pq.sv =====
// bt2020_ycbcr_to_rgb10_pq: BT.2020 limited-range YCbCr to packed A2R10G10B10.
// Depends on b2r_pkg (coefficients, code helper, PQ table).
//
// Usage:
//   Input channel: in_valid_i with luma_i, chroma_blue_i, chroma_red_i; the
//   block drives in_stall_o. A request is taken when valid is high and stall
//   is low. Output channel: out_valid_o with pixel_word_o; the sink drives
//   out_stall_i.
//   Config channel: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i;
//   index 0 is ten_bit_mode, index 1 is pq_enable, other indexes are dropped.
//   cfg_ready_o is always high; write only while the pipe is empty.
// Timing:
//   One pixel per cycle sustained while out_stall_i is low. The input register
//   feeds the result register that holds the matrix codes and the registered
//   reads of three PQ table copies, one per channel.
// Reset:
//   Both stages empty, ten_bit_mode = 1, pq_enable = 0.
// Stall:
//   A stalled result holds; the input register still takes one more request,
//   then in_stall_o rises until the sink takes the result.
module bt2020_ycbcr_to_rgb10_pq (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [b2r_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic                                cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [b2r_pkg::SAMPLE_W-1:0]        luma_i,
  input  logic [b2r_pkg::SAMPLE_W-1:0]        chroma_blue_i,
  input  logic [b2r_pkg::SAMPLE_W-1:0]        chroma_red_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [b2r_pkg::PIXEL_W-1:0]         pixel_word_o
);

  logic ten_bit_q;
  logic pq_en_q;

  logic                          s1_valid_q;
  logic [b2r_pkg::SAMPLE_W-1:0]  y_q, u_q, v_q;
  logic                          s2_valid_q;
  logic [b2r_pkg::CODE_W-1:0]    r_q, g_q, b_q;
  logic [b2r_pkg::CODE_W-1:0]    r_pq_q, g_pq_q, b_pq_q;

  logic s2_adv;
  logic in_acc;

  logic [b2r_pkg::SAMPLE_W-1:0]  ys, us, vs;
  logic signed [11:0]            yd, ud, vd;
  logic signed [31:0]            yd32, ud32, vd32;
  logic signed [31:0]            acc_y, acc_r, acc_g, acc_b;
  logic [b2r_pkg::CODE_W-1:0]    r_d, g_d, b_d;
  logic [b2r_pkg::CODE_W-1:0]    r_o, g_o, b_o;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ten_bit_q <= 1'b1;
      pq_en_q   <= 1'b0;
    end else if (cfg_valid_i) begin
      case (b2r_pkg::cfg_idx_e'(cfg_index_i))
        b2r_pkg::CFG_TEN_BIT_MODE: ten_bit_q <= cfg_data_i;
        b2r_pkg::CFG_PQ_ENABLE:    pq_en_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign s2_adv     = !s2_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !s2_adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s2_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s2_adv) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      y_q <= luma_i;
      u_q <= chroma_blue_i;
      v_q <= chroma_red_i;
    end
  end

  always_comb begin
    if (ten_bit_q) begin
      ys = y_q;
      us = u_q;
      vs = v_q;
    end else begin
      ys = {y_q[7:0], 2'b00};
      us = {u_q[7:0], 2'b00};
      vs = {v_q[7:0], 2'b00};
    end
    yd    = $signed({2'b00, ys}) - b2r_pkg::Y_OFS;
    ud    = $signed({2'b00, us}) - b2r_pkg::C_OFS;
    vd    = $signed({2'b00, vs}) - b2r_pkg::C_OFS;
    yd32  = 32'(yd);
    ud32  = 32'(ud);
    vd32  = 32'(vd);
    acc_y = b2r_pkg::KY * yd32;
    acc_r = acc_y + b2r_pkg::KRV * vd32;
    acc_g = acc_y - b2r_pkg::KGU * ud32 - b2r_pkg::KGV * vd32;
    acc_b = acc_y + b2r_pkg::KBU * ud32;
    r_d   = b2r_pkg::to_code(acc_r);
    g_d   = b2r_pkg::to_code(acc_g);
    b_d   = b2r_pkg::to_code(acc_b);
  end

  // result register plus registered PQ table reads
  always_ff @(posedge clk_i) begin
    if (s2_adv && s1_valid_q) begin
      r_q    <= r_d;
      g_q    <= g_d;
      b_q    <= b_d;
      r_pq_q <= b2r_pkg::PQ_ROM[r_d];
      g_pq_q <= b2r_pkg::PQ_ROM[g_d];
      b_pq_q <= b2r_pkg::PQ_ROM[b_d];
    end
  end

  assign r_o = pq_en_q ? r_pq_q : r_q;
  assign g_o = pq_en_q ? g_pq_q : g_q;
  assign b_o = pq_en_q ? b_pq_q : b_q;

  assign out_valid_o  = s2_valid_q;
  assign pixel_word_o = {b2r_pkg::ALPHA, r_o, g_o, b_o};

endmodule

// ===== rtl/b2r_checker.sv =====
// b2r_checker: port-level checks for bt2020_ycbcr_to_rgb10_pq, bound to it.
// Depends on b2r_pkg and assert_macros.svh.
`include "assert_macros.svh"

module b2r_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [b2r_pkg::PIXEL_W-1:0]   pixel_word_o
);

  `ASSERT_ALWAYS(a_alpha, clk_i, rst_ni, !out_valid_o || (pixel_word_o[31:30] == b2r_pkg::ALPHA))
  `ASSERT_ALWAYS(a_empty_accepts, clk_i, rst_ni, out_valid_o || !in_stall_o)
  `ASSERT_PROP(a_latency, clk_i, rst_ni, ((in_valid_i && !in_stall_o) |-> ##2 out_valid_o))
  `ASSERT_PROP(a_hold, clk_i, rst_ni, ((out_valid_o && out_stall_i) |=> (out_valid_o && $stable(pixel_word_o))))

endmodule

bind bt2020_ycbcr_to_rgb10_pq b2r_checker u_b2r_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .pixel_word_o (pixel_word_o)
);

// ===== verif/pixel_word_checker.sv =====
// pixel_word_checker: watches the config, pixel and result channels of the
// BT.2020 YCbCr to A2R10G10B10 converter and checks every result word.
// Depends on b2r_pkg for the config index width and codes only.
module pixel_word_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [b2r_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic                          cfg_data_i,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic [9:0]                    luma_i,
  input  logic [9:0]                    chroma_blue_i,
  input  logic [9:0]                    chroma_red_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic [31:0]                   pixel_word_i,
  output int                            mismatch_count_o,
  output int                            outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Q.16 matrix gains, 1023 output scale folded in
  localparam longint Y_GAIN    = 76533;
  localparam longint RV_GAIN   = 110337;
  localparam longint GU_GAIN   = 12312;
  localparam longint GV_GAIN   = 42751;
  localparam longint BU_GAIN   = 140776;
  localparam longint CODE_CEIL = longint'(1023) << 16;
  localparam logic [1:0] ALPHA_BITS = 2'b11;

  // ST 2084 constants in Q8.56
  localparam logic [63:0] Q_ONE = 64'd1 << 56;
  localparam logic [63:0] PQ_C1 = 64'd3424 << 44;
  localparam logic [63:0] PQ_C2 = 64'd2413 << 49;
  localparam logic [63:0] PQ_C3 = 64'd2392 << 49;

  typedef struct {
    logic [9:0]  luma;
    logic [9:0]  cb;
    logic [9:0]  cr;
    logic        ten_bit;
    logic        pq_on;
    logic [31:0] word;
  } pixel_req_t;

  logic [9:0]  pq_curve [1024];
  pixel_req_t  expected_pixels [$];
  logic        ten_bit_q;
  logic        pq_on_q;
  int          mismatch_total = 0;

  function automatic logic [63:0] q56_mul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[119:56];
  endfunction

  function automatic logic [63:0] q56_div(input logic [63:0] num, input logic [63:0] den);
    logic [127:0] wide;
    if (den == 64'd0) begin
      return 64'd0;
    end
    wide = ({64'd0, num} << 56) / {64'd0, den};
    return wide[63:0];
  endfunction

  function automatic logic [63:0] q56_root(input logic [63:0] a);
    logic [127:0] target;
    logic [127:0] sq;
    logic [63:0]  r;
    logic [63:0]  c;
    target = {64'd0, a} << 56;
    r = 64'd0;
    for (int bit_pos = 56; bit_pos >= 0; bit_pos--) begin
      c  = r | (64'd1 << bit_pos);
      sq = {64'd0, c} * {64'd0, c};
      if (sq <= target) begin
        r = c;
      end
    end
    return r;
  endfunction

  function automatic logic [63:0] q56_pow(input logic [63:0] base, input int unsigned e);
    logic [63:0] acc;
    logic [63:0] sq;
    int unsigned rest;
    acc  = Q_ONE;
    sq   = base;
    rest = e;
    while (rest != 0) begin
      if (rest[0]) begin
        acc = q56_mul(acc, sq);
      end
      sq   = q56_mul(sq, sq);
      rest = rest >> 1;
    end
    return acc;
  endfunction

  function automatic logic [9:0] pq_curve_code(input int unsigned idx);
    logic [63:0]  lin;
    logic [63:0]  lp;
    logic [63:0]  ratio;
    logic [63:0]  sig;
    logic [127:0] scaled;
    lin = q56_div(64'(idx), 64'd1023);
    for (int k = 0; k < 13; k++) begin
      lin = q56_root(lin);
    end
    lp    = q56_pow(lin, 1305);
    ratio = q56_div(PQ_C1 + q56_mul(PQ_C2, lp), Q_ONE + q56_mul(PQ_C3, lp));
    for (int k = 0; k < 5; k++) begin
      ratio = q56_root(ratio);
    end
    sig    = q56_pow(ratio, 2523);
    scaled = {64'd0, sig} * 128'd1023 + (128'd1 << 55);
    if (scaled[119:56] > 64'd1023) begin
      return 10'd1023;
    end
    return scaled[65:56];
  endfunction

  function automatic logic [9:0] channel_code(input longint acc);
    longint v;
    v = acc;
    if (v < 0) begin
      v = 0;
    end
    if (v > CODE_CEIL) begin
      v = CODE_CEIL;
    end
    return 10'((v + 32768) >>> 16);
  endfunction

  function automatic logic [31:0] convert_pixel(input logic [9:0] y, input logic [9:0] cb,
                                                input logic [9:0] cr, input logic ten_bit,
                                                input logic pq_on);
    longint ys;
    longint us;
    longint vs;
    longint yterm;
    logic [9:0] r;
    logic [9:0] g;
    logic [9:0] b;
    if (ten_bit) begin
      ys = longint'(y);
      us = longint'(cb);
      vs = longint'(cr);
    end else begin
      ys = longint'({y[7:0], 2'b00});
      us = longint'({cb[7:0], 2'b00});
      vs = longint'({cr[7:0], 2'b00});
    end
    yterm = (ys - 64) * Y_GAIN;
    r = channel_code(yterm + RV_GAIN * (vs - 512));
    g = channel_code(yterm - GU_GAIN * (us - 512) - GV_GAIN * (vs - 512));
    b = channel_code(yterm + BU_GAIN * (us - 512));
    if (pq_on) begin
      r = pq_curve[r];
      g = pq_curve[g];
      b = pq_curve[b];
    end
    return {ALPHA_BITS, r, g, b};
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_total++;
    $display("%0t ns pixel check: %s", $realtime, what);
  endtask

  initial begin
    for (int i = 0; i < 1024; i++) begin
      pq_curve[i] = pq_curve_code(i);
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : track
    pixel_req_t req;
    if (!rst_ni) begin
      ten_bit_q = 1'b1;
      pq_on_q   = 1'b0;
      expected_pixels.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch($sformatf("unexpected pixel word %h", pixel_word_i));
        end else begin
          req = expected_pixels.pop_front();
          if (pixel_word_i !== req.word) begin
            report_mismatch($sformatf("Y=%0d Cb=%0d Cr=%0d ten_bit=%0b pq=%0b exp %h got %h",
                                      req.luma, req.cb, req.cr, req.ten_bit, req.pq_on,
                                      req.word, pixel_word_i));
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        req.luma    = luma_i;
        req.cb      = chroma_blue_i;
        req.cr      = chroma_red_i;
        req.ten_bit = ten_bit_q;
        req.pq_on   = pq_on_q;
        req.word    = convert_pixel(luma_i, chroma_blue_i, chroma_red_i, ten_bit_q, pq_on_q);
        expected_pixels.push_back(req);
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          b2r_pkg::CFG_TEN_BIT_MODE: ten_bit_q = cfg_data_i;
          b2r_pkg::CFG_PQ_ENABLE:    pq_on_q   = cfg_data_i;
          default: ;
        endcase
      end
    end
    outstanding_o    <= expected_pixels.size();
    mismatch_count_o <= mismatch_total;
  end

endmodule

// ===== verif/tb.sv =====
// tb: drives pixels and register writes into bt2020_ycbcr_to_rgb10_pq with
// random gaps and sink stalls; pixel_word_checker does the checking.
// Depends on b2r_pkg, the block and pixel_word_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD  = 12;
  localparam int QUIET_LIMIT = 2000;
  localparam int PHASE_ITEMS = 140;
  localparam int LONG_HOLD   = 40;
  localparam logic [b2r_pkg::CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [b2r_pkg::CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

  logic                          clk        = 1'b0;
  logic                          rst_n      = 1'b0;
  logic                          cfg_valid  = 1'b0;
  logic [b2r_pkg::CFG_IDX_W-1:0] cfg_index  = '0;
  logic                          cfg_data   = 1'b0;
  logic                          in_valid   = 1'b0;
  logic [9:0]                    luma       = '0;
  logic [9:0]                    cb         = '0;
  logic [9:0]                    cr         = '0;
  logic                          out_stall  = 1'b0;
  logic                          cfg_ready;
  logic                          in_stall;
  logic                          out_valid;
  logic [31:0]                   pixel_word;
  int                            mismatches;
  int                            pending;
  bit                            calm = 1'b0;
  int                            pixels_sent = 0;
  int                            reg_writes = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  bt2020_ycbcr_to_rgb10_pq DUT (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .luma_i        (luma),
    .chroma_blue_i (cb),
    .chroma_red_i  (cr),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .pixel_word_o  (pixel_word)
  );

  pixel_word_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .luma_i           (luma),
    .chroma_blue_i    (cb),
    .chroma_red_i     (cr),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .pixel_word_i     (pixel_word),
    .mismatch_count_o (mismatches),
    .outstanding_o    (pending)
  );

  function automatic logic [9:0] pick_sample(input int unsigned nominal_top);
    case ($urandom_range(0, 9))
      0:       return 10'd0;
      1:       return 10'd1023;
      2, 3:    return 10'($urandom_range(64, nominal_top));
      default: return 10'($urandom_range(0, 1023));
    endcase
  endfunction

  task automatic send_pixel(input logic [9:0] y, input logic [9:0] b, input logic [9:0] r);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    luma     <= y;
    cb       <= b;
    cr       <= r;
    do @(posedge clk); while (in_stall);
    pixels_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [b2r_pkg::CFG_IDX_W-1:0] idx, input logic val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    reg_writes++;
  endtask

  task automatic set_mode(input logic ten_bit, input logic pq_on);
    wait_idle();
    write_reg(b2r_pkg::CFG_TEN_BIT_MODE, ten_bit);
    write_reg(b2r_pkg::CFG_PQ_ENABLE, pq_on);
  endtask

  task automatic run_random(input logic ten_bit, input logic pq_on, input bit drain_mid);
    set_mode(ten_bit, pq_on);
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      // sender pause until the pipe is empty
      if (drain_mid && n == PHASE_ITEMS / 2) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
      end
      send_pixel(pick_sample(940), pick_sample(960), pick_sample(960));
    end
  endtask

  // sink: short random stalls plus one long hold-off to fill the pipe
  initial begin : sink
    int taken;
    bit held;
    taken = 0;
    held  = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        taken++;
      end
      if (!held && taken >= 250) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("[bt2020_ycbcr_to_rgb10_pq] ERROR");
    $finish;
  end

  initial begin : stimulus
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: 10-bit, PQ off; extremes, nominal black/white, clipping
    send_pixel(10'd0, 10'd0, 10'd0);
    send_pixel(10'd1023, 10'd1023, 10'd1023);
    send_pixel(10'd64, 10'd512, 10'd512);
    send_pixel(10'd940, 10'd512, 10'd512);
    send_pixel(10'd940, 10'd512, 10'd960);
    send_pixel(10'd940, 10'd960, 10'd64);
    send_pixel(10'd64, 10'd64, 10'd960);
    send_pixel(10'd1023, 10'd0, 10'd1023);
    send_pixel(10'd0, 10'd1023, 10'd0);
    send_pixel(10'd512, 10'd0, 10'd0);
    send_pixel(10'h2AA, 10'h155, 10'h2AA);
    send_pixel(10'h155, 10'h2AA, 10'h155);

    set_mode(1'b1, 1'b1);
    send_pixel(10'd64, 10'd512, 10'd512);
    send_pixel(10'd940, 10'd512, 10'd512);
    send_pixel(10'd502, 10'd512, 10'd512);
    send_pixel(10'd1023, 10'd1023, 10'd1023);

    // 8-bit samples: upper two bits must be ignored
    set_mode(1'b0, 1'b1);
    send_pixel(10'h3EB, 10'h380, 10'h380);
    send_pixel(10'd16, 10'd128, 10'd128);
    send_pixel(10'h300, 10'h3FF, 10'h000);
    send_pixel(10'd255, 10'd255, 10'd255);

    // writes to unused indexes must change nothing
    wait_idle();
    write_reg(CFG_SPARE_2, 1'b1);
    write_reg(CFG_SPARE_3, 1'b0);
    send_pixel(10'h3EB, 10'h180, 10'h280);
    send_pixel(10'h0FF, 10'h200, 10'h100);

    run_random(1'b1, 1'b0, 1'b1);
    run_random(1'b1, 1'b1, 1'b0);
    run_random(1'b0, 1'b1, 1'b0);
    run_random(1'b0, 1'b0, 1'b0);
    calm = 1'b1;
    run_random(1'b1, 1'b1, 1'b0);

    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);

    $display("covered %0d pixels, %0d register writes: 8/10-bit samples, PQ on/off,",
             pixels_sent, reg_writes);
    $display("random gaps and sink stalls, one %0d-cycle hold-off and a drain pause",
             LONG_HOLD);
    if (mismatches == 0 && pending == 0) begin
      $display("[bt2020_ycbcr_to_rgb10_pq] OK");
    end else begin
      $display("[bt2020_ycbcr_to_rgb10_pq] ERROR");
    end
    $finish;
  end

endmodule
